>>> rtl/hcb_pkg.sv
package hcb_pkg;

    localparam int SYM_W     = 8;
    localparam int SYMBOLS   = 256;
    localparam int CNT_W     = 16;
    localparam int CODE_W    = 24;
    localparam int LEN_W     = 5;
    localparam int NODES     = 511;
    localparam int NODE_AW   = 9;
    localparam int TC_W      = 9;
    localparam int FOREST_W  = CNT_W + NODE_AW;
    localparam int NODE_W    = 1 + SYM_W + 2 * NODE_AW;
    localparam int NCODE_W   = LEN_W + CODE_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(CODE_W + 1);

    // actions carried in s_tuser
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // datapath operations
    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_LATCH = 5'd1;
    localparam logic [4:0] OP_HRD   = 5'd2;
    localparam logic [4:0] OP_HWR   = 5'd3;
    localparam logic [4:0] OP_CLR   = 5'd4;
    localparam logic [4:0] OP_QRD   = 5'd5;
    localparam logic [4:0] OP_QRES  = 5'd6;
    localparam logic [4:0] OP_BINIT = 5'd7;
    localparam logic [4:0] OP_SCAN  = 5'd8;
    localparam logic [4:0] OP_BEMP  = 5'd9;
    localparam logic [4:0] OP_PINIT = 5'd10;
    localparam logic [4:0] OP_PICK  = 5'd11;
    localparam logic [4:0] OP_M1    = 5'd12;
    localparam logic [4:0] OP_M2    = 5'd13;
    localparam logic [4:0] OP_M3    = 5'd14;
    localparam logic [4:0] OP_WINIT = 5'd15;
    localparam logic [4:0] OP_WRD   = 5'd16;
    localparam logic [4:0] OP_WDAT  = 5'd17;
    localparam logic [4:0] OP_WRGT  = 5'd18;
    localparam logic [4:0] OP_BRES  = 5'd19;
    localparam logic [4:0] OP_OUT   = 5'd20;

    typedef struct packed {
        logic [4:0] op;
    } hcb_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pick_done;
        logic tc_zero;
        logic tc_one;
        logic n_zero;
        logic out_free;
    } hcb_stat_t;

endpackage

>>> rtl/huffman_code_builder_top.sv
// Add, query and clear: one beat in, result registered for output from DONE once the output is free.
// Build: histogram scan, then per merge a forest scan (PICK) and merge (M1 to M3),
// then a code walk that reads each tree node and writes its left and right codes.
// One beat is worked on at a time; the next is taken once its result is queued.
// Reset (aresetn low, synchronous) empties histogram, totals and code table.
module huffman_code_builder_top import hcb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value[7:0]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[1:0], symbol_present[2], code_length[7:3],
                                   // code_bits[31:8]
);

    hcb_cmd_t  cmd;
    hcb_stat_t stat;

    hcb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hcb_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_sym      (s_tdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tdata[1:0]),
        .out_present (m_tdata[2]),
        .out_len     (m_tdata[7:3]),
        .out_bits    (m_tdata[31:8])
    );

endmodule

>>> rtl/hcb_ctrl.sv
module hcb_ctrl import hcb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [1:0] in_action,
    output logic       in_ready,
    input  hcb_stat_t  stat,
    output hcb_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ADRD  = 5'd1;
    localparam logic [4:0] S_ADWR  = 5'd2;
    localparam logic [4:0] S_CLR   = 5'd3;
    localparam logic [4:0] S_QRD   = 5'd4;
    localparam logic [4:0] S_QRES  = 5'd5;
    localparam logic [4:0] S_BINIT = 5'd6;
    localparam logic [4:0] S_SCAN  = 5'd7;
    localparam logic [4:0] S_BEMP  = 5'd8;
    localparam logic [4:0] S_PINIT = 5'd9;
    localparam logic [4:0] S_PICK  = 5'd10;
    localparam logic [4:0] S_M1    = 5'd11;
    localparam logic [4:0] S_M2    = 5'd12;
    localparam logic [4:0] S_M3    = 5'd13;
    localparam logic [4:0] S_WINIT = 5'd14;
    localparam logic [4:0] S_WRD   = 5'd15;
    localparam logic [4:0] S_WDAT  = 5'd16;
    localparam logic [4:0] S_WRGT  = 5'd17;
    localparam logic [4:0] S_BRES  = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    logic [4:0] state_reg, state_next;

    // sequence the datapath one operation per cycle, holding in S_DONE while the output is not free
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op = OP_LATCH;
                    case (in_action)
                        ACT_ADD:   state_next = S_ADRD;
                        ACT_BUILD: state_next = S_BINIT;
                        ACT_QUERY: state_next = S_QRD;
                        default:   state_next = S_CLR;
                    endcase
                end
            end
            S_ADRD:  begin cmd.op = OP_HRD;  state_next = S_ADWR; end
            S_ADWR:  begin cmd.op = OP_HWR;  state_next = S_DONE; end
            S_CLR:   begin cmd.op = OP_CLR;  state_next = S_DONE; end
            S_QRD:   begin cmd.op = OP_QRD;  state_next = S_QRES; end
            S_QRES:  begin cmd.op = OP_QRES; state_next = S_DONE; end
            S_BINIT: begin cmd.op = OP_BINIT; state_next = S_SCAN; end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (stat.scan_done) begin
                    if (stat.tc_zero)     state_next = S_BEMP;
                    else if (stat.tc_one) state_next = S_WINIT;
                    else                  state_next = S_PINIT;
                end
            end
            S_BEMP:  begin cmd.op = OP_BEMP;  state_next = S_DONE; end
            S_PINIT: begin cmd.op = OP_PINIT; state_next = S_PICK; end
            S_PICK: begin
                cmd.op = OP_PICK;
                if (stat.pick_done) state_next = S_M1;
            end
            S_M1:    begin cmd.op = OP_M1; state_next = S_M2; end
            S_M2:    begin cmd.op = OP_M2; state_next = S_M3; end
            S_M3: begin
                cmd.op     = OP_M3;
                state_next = stat.tc_one ? S_WINIT : S_PINIT;
            end
            S_WINIT: begin cmd.op = OP_WINIT; state_next = S_WRD; end
            S_WRD:   begin cmd.op = OP_WRD;   state_next = S_WDAT; end
            S_WDAT:  begin cmd.op = OP_WDAT;  state_next = S_WRGT; end
            S_WRGT: begin
                cmd.op     = OP_WRGT;
                state_next = stat.n_zero ? S_BRES : S_WRD;
            end
            S_BRES:  begin cmd.op = OP_BRES; state_next = S_DONE; end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/hcb_datapath.sv
module hcb_datapath import hcb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  hcb_cmd_t          cmd,
    output hcb_stat_t         stat,
    input  logic [SYM_W-1:0]  in_sym,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_status,
    output logic              out_present,
    output logic [LEN_W-1:0]  out_len,
    output logic [CODE_W-1:0] out_bits
);

    // memories
    logic [CNT_W-1:0]    hist_mem  [SYMBOLS];
    logic [FOREST_W-1:0] frst_mem  [SYMBOLS];
    logic [NODE_W-1:0]   node_mem  [NODES];
    logic [NCODE_W-1:0]  ncode_mem [NODES];
    logic [NCODE_W-1:0]  ctab_mem  [SYMBOLS];

    logic                h_we, h_re;
    logic [SYM_W-1:0]    h_waddr, h_raddr;
    logic [CNT_W-1:0]    h_wdata, h_rdata_reg;
    logic                hv_rd_reg, hv_rd_next;
    logic                f_we, f_re;
    logic [SYM_W-1:0]    f_waddr, f_raddr;
    logic [FOREST_W-1:0] f_wdata, f_rdata_reg;
    logic                nd_we, nd_re;
    logic [NODE_AW-1:0]  nd_waddr, nd_raddr;
    logic [NODE_W-1:0]   nd_wdata, nd_rdata_reg;
    logic                nc_we, nc_re;
    logic [NODE_AW-1:0]  nc_waddr, nc_raddr;
    logic [NCODE_W-1:0]  nc_wdata, nc_rdata_reg;
    logic                ct_we, ct_re;
    logic [SYM_W-1:0]    ct_waddr, ct_raddr;
    logic [NCODE_W-1:0]  ct_wdata, ct_rdata_reg;
    logic                cv_rd_reg, cv_rd_next;

    logic [SYMBOLS-1:0]  hvalid_reg, hvalid_next;
    logic [SYMBOLS-1:0]  cvalid_reg, cvalid_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                ovf_reg, ovf_next;
    logic [TC_W-1:0]     tc_reg, tc_next;
    logic [NODE_AW-1:0]  used_reg, used_next;
    logic [TC_W-1:0]     scnt_reg, scnt_next;
    logic                pv_reg, pv_next;
    logic [SYM_W-1:0]    psym_reg, psym_next;
    logic [TC_W-1:0]     k_reg, k_next;
    logic [SYM_W-1:0]    aidx_reg, aidx_next, bidx_reg, bidx_next;
    logic [CNT_W-1:0]    aw_reg, aw_next, bw_reg, bw_next;
    logic [NODE_AW-1:0]  ar_reg, ar_next, br_reg, br_next;
    logic [NODE_AW-1:0]  n_reg, n_next;
    logic [1:0]          rst_reg, rst_next;
    logic                rpr_reg, rpr_next;
    logic [LEN_W-1:0]    rln_reg, rln_next;
    logic [CODE_W-1:0]   rbt_reg, rbt_next;
    logic                ov_reg, ov_next;
    logic [1:0]          ost_reg, ost_next;
    logic                opr_reg, opr_next;
    logic [LEN_W-1:0]    oln_reg, oln_next;
    logic [CODE_W-1:0]   obt_reg, obt_next;

    logic [CNT_W-1:0]    h_val, f_w;
    logic [NODE_AW-1:0]  f_r;
    logic                nd_leaf;
    logic [SYM_W-1:0]    nd_sym;
    logic [NODE_AW-1:0]  nd_left, nd_right;
    logic [LEN_W-1:0]    nc_len, nc_len_inc;
    logic [CODE_W-1:0]   nc_bits, nc_bits_sh;

    assign h_val      = hv_rd_reg ? h_rdata_reg : '0;
    assign f_w        = f_rdata_reg[FOREST_W-1:NODE_AW];
    assign f_r        = f_rdata_reg[NODE_AW-1:0];
    assign nd_leaf    = nd_rdata_reg[NODE_W-1];
    assign nd_sym     = nd_rdata_reg[2*NODE_AW +: SYM_W];
    assign nd_left    = nd_rdata_reg[NODE_AW +: NODE_AW];
    assign nd_right   = nd_rdata_reg[NODE_AW-1:0];
    assign nc_len     = nc_rdata_reg[NCODE_W-1:CODE_W];
    assign nc_bits    = nc_rdata_reg[CODE_W-1:0];
    assign nc_len_inc = (nc_len == LEN_OVER) ? LEN_OVER : nc_len + 1'b1;
    assign nc_bits_sh = {nc_bits[CODE_W-2:0], 1'b0};

    assign stat.scan_done = (scnt_reg == TC_W'(SYMBOLS)) && !pv_reg;
    assign stat.pick_done = (k_reg == tc_reg) && !pv_reg;
    assign stat.tc_zero   = (tc_reg == '0);
    assign stat.tc_one    = (tc_reg == TC_W'(1));
    assign stat.n_zero    = (n_reg == '0);
    assign stat.out_free  = !ov_reg || out_ready;

    assign out_valid   = ov_reg;
    assign out_status  = ost_reg;
    assign out_present = opr_reg;
    assign out_len     = oln_reg;
    assign out_bits    = obt_reg;

    // decode the operation into register and memory updates
    always_comb begin
        hvalid_next = hvalid_reg;  cvalid_next = cvalid_reg;
        sym_next = sym_reg;  total_next = total_reg;  ovf_next = ovf_reg;
        tc_next = tc_reg;  used_next = used_reg;  scnt_next = scnt_reg;
        pv_next = pv_reg;  psym_next = psym_reg;  k_next = k_reg;
        aidx_next = aidx_reg;  bidx_next = bidx_reg;
        aw_next = aw_reg;  bw_next = bw_reg;  ar_next = ar_reg;  br_next = br_reg;
        n_next = n_reg;
        rst_next = rst_reg;  rpr_next = rpr_reg;  rln_next = rln_reg;  rbt_next = rbt_reg;
        ost_next = ost_reg;  opr_next = opr_reg;  oln_next = oln_reg;  obt_next = obt_reg;
        ov_next = ov_reg && !out_ready;
        hv_rd_next = hv_rd_reg;  cv_rd_next = cv_rd_reg;
        h_we = 1'b0;  h_re = 1'b0;  h_waddr = sym_reg;  h_raddr = sym_reg;  h_wdata = '0;
        f_we = 1'b0;  f_re = 1'b0;  f_waddr = '0;  f_raddr = '0;  f_wdata = '0;
        nd_we = 1'b0; nd_re = 1'b0; nd_waddr = used_reg; nd_raddr = n_reg; nd_wdata = '0;
        nc_we = 1'b0; nc_re = 1'b0; nc_waddr = '0; nc_raddr = n_reg; nc_wdata = '0;
        ct_we = 1'b0; ct_re = 1'b0; ct_waddr = nd_sym; ct_raddr = sym_reg; ct_wdata = '0;
        case (cmd.op)
            OP_LATCH: sym_next = in_sym;
            OP_HRD: begin
                h_re       = 1'b1;
                hv_rd_next = hvalid_reg[sym_reg];
            end
            OP_HWR: begin
                rpr_next = 1'b0;  rln_next = '0;  rbt_next = '0;
                if (total_reg == CNT_MAX) begin
                    ovf_next = 1'b1;
                    rst_next = ST_SAT;
                end else begin
                    total_next           = total_reg + 1'b1;
                    h_we                 = 1'b1;
                    h_wdata              = h_val + 1'b1;
                    hvalid_next[sym_reg] = 1'b1;
                    rst_next             = ST_OK;
                end
            end
            OP_CLR: begin
                hvalid_next = '0;  cvalid_next = '0;
                total_next = '0;  ovf_next = 1'b0;  tc_next = '0;
                rst_next = ST_OK;  rpr_next = 1'b0;  rln_next = '0;  rbt_next = '0;
            end
            OP_QRD: begin
                ct_re      = 1'b1;
                cv_rd_next = cvalid_reg[sym_reg];
            end
            OP_QRES: begin
                rst_next = ST_OK;
                rpr_next = cv_rd_reg;
                rln_next = cv_rd_reg ? ct_rdata_reg[NCODE_W-1:CODE_W] : '0;
                rbt_next = cv_rd_reg ? ct_rdata_reg[CODE_W-1:0] : '0;
            end
            OP_BINIT: begin
                cvalid_next = '0;
                tc_next = '0;  used_next = '0;  scnt_next = '0;  pv_next = 1'b0;
            end
            OP_SCAN: begin
                // place a leaf for each symbol that occurred
                if (pv_reg && (h_val != '0)) begin
                    nd_we     = 1'b1;
                    nd_wdata  = {1'b1, psym_reg, {NODE_AW{1'b0}}, {NODE_AW{1'b0}}};
                    f_we      = 1'b1;
                    f_waddr   = tc_reg[SYM_W-1:0];
                    f_wdata   = {h_val, used_reg};
                    tc_next   = tc_reg + 1'b1;
                    used_next = used_reg + 1'b1;
                end
                // issue the next histogram read
                if (scnt_reg != TC_W'(SYMBOLS)) begin
                    h_re       = 1'b1;
                    h_raddr    = scnt_reg[SYM_W-1:0];
                    hv_rd_next = hvalid_reg[scnt_reg[SYM_W-1:0]];
                    pv_next    = 1'b1;
                    psym_next  = scnt_reg[SYM_W-1:0];
                    scnt_next  = scnt_reg + 1'b1;
                end else begin
                    pv_next = 1'b0;
                end
            end
            OP_BEMP: begin
                rst_next = ST_EMPTY;  rpr_next = 1'b0;  rln_next = '0;  rbt_next = '0;
            end
            OP_PINIT: begin
                k_next  = '0;
                pv_next = 1'b0;
            end
            OP_PICK: begin
                // track the two lightest trees, ties to the later slot (slot 1 does not displace slot 0 on a tie)
                if (pv_reg) begin
                    if (psym_reg == '0) begin
                        aidx_next = psym_reg;  aw_next = f_w;  ar_next = f_r;
                    end else if (psym_reg == SYM_W'(1)) begin
                        if (f_w < aw_reg) begin
                            bidx_next = aidx_reg;  bw_next = aw_reg;  br_next = ar_reg;
                            aidx_next = psym_reg;  aw_next = f_w;     ar_next = f_r;
                        end else begin
                            bidx_next = psym_reg;  bw_next = f_w;     br_next = f_r;
                        end
                    end else if (f_w <= aw_reg) begin
                        bidx_next = aidx_reg;  bw_next = aw_reg;  br_next = ar_reg;
                        aidx_next = psym_reg;  aw_next = f_w;     ar_next = f_r;
                    end else if (f_w <= bw_reg) begin
                        bidx_next = psym_reg;  bw_next = f_w;     br_next = f_r;
                    end
                end
                if (k_reg != tc_reg) begin
                    f_re      = 1'b1;
                    f_raddr   = k_reg[SYM_W-1:0];
                    pv_next   = 1'b1;
                    psym_next = k_reg[SYM_W-1:0];
                    k_next    = k_reg + 1'b1;
                end else begin
                    pv_next = 1'b0;
                end
            end
            OP_M1: begin
                nd_we = 1'b1;
                if (aidx_reg < bidx_reg) begin
                    nd_wdata = {1'b0, {SYM_W{1'b0}}, ar_reg, br_reg};
                end else begin
                    nd_wdata = {1'b0, {SYM_W{1'b0}}, br_reg, ar_reg};
                end
                f_we      = 1'b1;
                f_waddr   = aidx_reg;
                f_wdata   = {aw_reg + bw_reg, used_reg};
                used_next = used_reg + 1'b1;
                tc_next   = tc_reg - 1'b1;
            end
            OP_M2: begin
                f_re    = 1'b1;
                f_raddr = tc_reg[SYM_W-1:0];
            end
            OP_M3: begin
                f_we    = 1'b1;
                f_waddr = bidx_reg;
                f_wdata = f_rdata_reg;
            end
            OP_WINIT: begin
                n_next   = used_reg - 1'b1;
                nc_we    = 1'b1;
                nc_waddr = used_reg - 1'b1;
                nc_wdata = '0;
            end
            OP_WRD: begin
                nd_re = 1'b1;
                nc_re = 1'b1;
            end
            OP_WDAT: begin
                if (nd_leaf) begin
                    if (nc_len < LEN_OVER) begin
                        ct_we               = 1'b1;
                        ct_wdata            = nc_rdata_reg;
                        cvalid_next[nd_sym] = 1'b1;
                    end
                end else begin
                    nc_we    = 1'b1;
                    nc_waddr = nd_left;
                    nc_wdata = {nc_len_inc, nc_bits_sh};
                end
            end
            OP_WRGT: begin
                if (!nd_leaf) begin
                    nc_we    = 1'b1;
                    nc_waddr = nd_right;
                    nc_wdata = {nc_len_inc, nc_bits_sh | CODE_W'(1)};
                end
                n_next = n_reg - 1'b1;
            end
            OP_BRES: begin
                rst_next = ovf_reg ? ST_SAT : ST_OK;
                rpr_next = 1'b0;  rln_next = '0;  rbt_next = '0;
            end
            OP_OUT: begin
                ov_next  = 1'b1;
                ost_next = rst_reg;  opr_next = rpr_reg;
                oln_next = rln_reg;  obt_next = rbt_reg;
            end
            default: ;
        endcase
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (h_we) hist_mem[h_waddr] <= h_wdata;
        if (h_re) h_rdata_reg <= hist_mem[h_raddr];
    end

    always_ff @(posedge aclk) begin
        if (f_we) frst_mem[f_waddr] <= f_wdata;
        if (f_re) f_rdata_reg <= frst_mem[f_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nd_we) node_mem[nd_waddr] <= nd_wdata;
        if (nd_re) nd_rdata_reg <= node_mem[nd_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nc_we) ncode_mem[nc_waddr] <= nc_wdata;
        if (nc_re) nc_rdata_reg <= ncode_mem[nc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ct_we) ctab_mem[ct_waddr] <= ct_wdata;
        if (ct_re) ct_rdata_reg <= ctab_mem[ct_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hvalid_reg <= '0;
            cvalid_reg <= '0;
            total_reg  <= '0;
            ovf_reg    <= 1'b0;
            tc_reg     <= '0;
            used_reg   <= '0;
            scnt_reg   <= '0;
            pv_reg     <= 1'b0;
            k_reg      <= '0;
            n_reg      <= '0;
            ov_reg     <= 1'b0;
        end else begin
            hvalid_reg <= hvalid_next;
            cvalid_reg <= cvalid_next;
            total_reg  <= total_next;
            ovf_reg    <= ovf_next;
            tc_reg     <= tc_next;
            used_reg   <= used_next;
            scnt_reg   <= scnt_next;
            pv_reg     <= pv_next;
            k_reg      <= k_next;
            n_reg      <= n_next;
            ov_reg     <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sym_reg   <= sym_next;
        psym_reg  <= psym_next;
        hv_rd_reg <= hv_rd_next;
        cv_rd_reg <= cv_rd_next;
        aidx_reg  <= aidx_next;
        bidx_reg  <= bidx_next;
        aw_reg    <= aw_next;
        bw_reg    <= bw_next;
        ar_reg    <= ar_next;
        br_reg    <= br_next;
        rst_reg   <= rst_next;
        rpr_reg   <= rpr_next;
        rln_reg   <= rln_next;
        rbt_reg   <= rbt_next;
        ost_reg   <= ost_next;
        opr_reg   <= opr_next;
        oln_reg   <= oln_next;
        obt_reg   <= obt_next;
    end

endmodule
